// ----- sv/brake_motor_ramp_controller_defines.svh -----
// Assertion macros for the brake controller checker file.
`ifndef BRAKE_MOTOR_RAMP_CONTROLLER_DEFINES_SVH
`define BRAKE_MOTOR_RAMP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BMRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("brake controller check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define BMRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("brake controller check failed");

`endif

// ----- sv/bmrc_pkg.sv -----
// Shared types and constants for the brake motor ramp controller.
package bmrc_pkg;

  // Item field widths
  localparam int unsigned StickW = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SpeedW = 12;
  localparam int unsigned PotW   = 10;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned ModeW  = 3;

  // Packed stream widths (rounded up to whole bytes)
  localparam int unsigned InFieldsW  = 2 * StickW + TimeW + SpeedW + 1 + PotW;
  localparam int unsigned InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = 1 + DutyW + ModeW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgTightenDir  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPotCenter   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNoInputDly  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxDuty     = 2'd3;

  localparam logic             RstTightenDir = 1'b1;
  localparam logic [PotW-1:0]  RstPotCenter  = 10'd512;
  localparam logic [TimeW-1:0] RstNoInputDly = 32'd100000;
  localparam logic [DutyW-1:0] RstMaxDuty    = 8'd50;

  // Control constants
  localparam logic [StickW-1:0] StickDown   = 8'd135;
  localparam logic [StickW-1:0] IdleLow     = 8'd124;
  localparam logic [StickW-1:0] IdleHigh    = 8'd132;
  localparam logic [SpeedW-1:0] SpeedHighFx = 12'd160;
  localparam logic [SpeedW-1:0] SpeedMoveFx = 12'd16;
  localparam logic [PotW:0]     PotBand     = 11'd5;
  localparam logic [DutyW-1:0]  BaseDuty    = 8'd20;
  localparam logic [DutyW-1:0]  DutySat     = 8'd255;

  // Ramp: 40 * t / 1000 == t / 25. Saturates at 255 once t >= 256 * 25.
  // Below that t fits 13 bits and t / 25 == (t * 5243) >> 17 exactly.
  localparam int unsigned RampDivW   = 13;
  localparam int unsigned RampShift  = 17;
  localparam logic [TimeW-1:0]    RampSatTicks = 32'd6400;
  localparam logic [RampDivW-1:0] RampRecip    = 13'd5243;

  typedef enum logic [ModeW-1:0] {
    ModeEmergency   = 3'd0,
    ModeBrake       = 3'd1,
    ModeTimeout     = 3'd2,
    ModeRecenterL   = 3'd3,
    ModeRecenterR   = 3'd4,
    ModeReleased    = 3'd5
  } mode_e;

endpackage

// ----- sv/brake_motor_ramp_controller.sv -----
// Brake motor ramp controller: one control tick per stream item.
//
// Each accepted input item is one control tick. The block decides to tighten
// the brake (emergency, stick pulled down, speed above 10, or no stick motion
// for over no_input_delay ticks), to recenter it on the potentiometer, or to
// release it, and returns one result item with the direction level, the PWM
// duty and a mode code. While braking, the duty follows elapsed/25 since the
// last release (40 per 1000 ticks), saturating at 255, never lowered and
// clamped at max_brake_duty. Rate: one item per clock while the sink takes
// results. Items pass an input register, then the decision logic (one 32-bit
// subtract, a 13x13 reciprocal multiply for the divide by 25, compares)
// feeding the result register. The controller state updates on the same edge
// that loads the result, so the next tick sees it with no bubble. Both stages
// move while the result is taken, so a stalled sink only holds the pipeline,
// it never drops or repeats items. A plain write port with no read-back sets
// config (0 tighten_dir, 1 pot_center, 2 no_input_delay, 3 max_brake_duty);
// users write it only while the block is idle; the block does not enforce it.
module brake_motor_ramp_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [bmrc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bmrc_pkg::CfgDataW-1:0]    cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata, low bit up: stick_y[7:0], stick_x[15:8], now_time[47:16],
  // speed_fx[59:48], emergency[60], pot_value[70:61], zero fill [71]
  input  logic [bmrc_pkg::InDataW-1:0]     s_axis_tdata_i,
  // result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata, low bit up: direction[0], speed_duty[8:1], mode_code[11:9],
  // zero fill [15:12]
  output logic [bmrc_pkg::OutDataW-1:0]    m_axis_tdata_o
);

  localparam int unsigned StickW = bmrc_pkg::StickW;
  localparam int unsigned TimeW  = bmrc_pkg::TimeW;
  localparam int unsigned SpeedW = bmrc_pkg::SpeedW;
  localparam int unsigned PotW   = bmrc_pkg::PotW;
  localparam int unsigned DutyW  = bmrc_pkg::DutyW;
  localparam int unsigned DivW   = bmrc_pkg::RampDivW;
  localparam int unsigned ProdW  = 2 * DivW;
  localparam int unsigned Shift  = bmrc_pkg::RampShift;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic             tighten_dir_q;
  logic [PotW-1:0]  pot_center_q;
  logic [TimeW-1:0] no_input_delay_q;
  logic [DutyW-1:0] max_duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tighten_dir_q    <= bmrc_pkg::RstTightenDir;
      pot_center_q     <= bmrc_pkg::RstPotCenter;
      no_input_delay_q <= bmrc_pkg::RstNoInputDly;
      max_duty_q       <= bmrc_pkg::RstMaxDuty;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmrc_pkg::CfgTightenDir: tighten_dir_q    <= cfg_data_i[0];
        bmrc_pkg::CfgPotCenter:  pot_center_q     <= cfg_data_i[PotW-1:0];
        bmrc_pkg::CfgNoInputDly: no_input_delay_q <= cfg_data_i[TimeW-1:0];
        bmrc_pkg::CfgMaxDuty:    max_duty_q       <= cfg_data_i[DutyW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake: input stage -> result stage
  // ---------------------------------------------------------------------
  logic                                    in_valid_q;
  logic [bmrc_pkg::InFieldsW-1:0]          in_data_q;
  logic                                    out_valid_q;
  logic                                    out_dir_q;
  logic [DutyW-1:0]                        out_duty_q;
  bmrc_pkg::mode_e                         out_mode_q;

  logic out_free;   // result register can take a new item this cycle
  logic advance;    // input stage item moves into the result register

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i[bmrc_pkg::InFieldsW-1:0];
    end
  end

  // field unpack
  logic [StickW-1:0] stick_y;
  logic [StickW-1:0] stick_x;
  logic [TimeW-1:0]  now_time;
  logic [SpeedW-1:0] speed_fx;
  logic              emergency;
  logic [PotW-1:0]   pot_value;

  assign stick_y   = in_data_q[7:0];
  assign stick_x   = in_data_q[15:8];
  assign now_time  = in_data_q[47:16];
  assign speed_fx  = in_data_q[59:48];
  assign emergency = in_data_q[60];
  assign pot_value = in_data_q[70:61];

  // ---------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------
  logic [DutyW-1:0] brake_duty_q, brake_duty_d;
  logic [TimeW-1:0] ramp_start_q, ramp_start_d;
  logic [TimeW-1:0] last_input_q, last_input_d;
  logic             dir_level_q, dir_level_d;

  // ---------------------------------------------------------------------
  // Ramp term: elapsed / 25, saturated at 255
  // ---------------------------------------------------------------------
  logic [TimeW-1:0] elapsed;
  logic             ramp_sat;
  logic [ProdW-1:0] ramp_prod;
  logic [DutyW-1:0] ramp_term;
  logic [DutyW-1:0] ramp_max;
  logic [DutyW-1:0] ramp_duty;

  assign elapsed   = now_time - ramp_start_q;
  assign ramp_sat  = elapsed >= bmrc_pkg::RampSatTicks;
  assign ramp_prod = {{DivW{1'b0}}, elapsed[DivW-1:0]}
                   * {{DivW{1'b0}}, bmrc_pkg::RampRecip};
  assign ramp_term = ramp_sat ? bmrc_pkg::DutySat : ramp_prod[Shift+DutyW-1:Shift];
  // never lowered by the ramp, then clamped (clamp may pull it down)
  assign ramp_max  = (ramp_term > brake_duty_q) ? ramp_term : brake_duty_q;
  assign ramp_duty = (ramp_max > max_duty_q) ? max_duty_q : ramp_max;

  // ---------------------------------------------------------------------
  // Decision
  // ---------------------------------------------------------------------
  logic          brake_req;
  logic          timed_out;
  logic          moving;
  logic          pot_low;
  logic          pot_high;
  logic          stick_active;
  logic [TimeW:0] idle_deadline;

  assign brake_req     = (stick_y > bmrc_pkg::StickDown) || (speed_fx > bmrc_pkg::SpeedHighFx);
  assign moving        = speed_fx >= bmrc_pkg::SpeedMoveFx;
  // 33-bit sum, no wrap
  assign idle_deadline = {1'b0, last_input_q} + {1'b0, no_input_delay_q};
  assign timed_out     = idle_deadline < {1'b0, now_time};
  // deadband of +-5 around the center, compared at 11 bits
  assign pot_low       = ({1'b0, pot_value} + bmrc_pkg::PotBand) < {1'b0, pot_center_q};
  assign pot_high      = {1'b0, pot_value} > ({1'b0, pot_center_q} + bmrc_pkg::PotBand);
  assign stick_active  = !((stick_x >= bmrc_pkg::IdleLow) && (stick_x <= bmrc_pkg::IdleHigh))
                      || !((stick_y >= bmrc_pkg::IdleLow) && (stick_y <= bmrc_pkg::IdleHigh));

  logic [DutyW-1:0] duty_d;
  bmrc_pkg::mode_e  mode_d;

  always_comb begin
    brake_duty_d = brake_duty_q;
    ramp_start_d = ramp_start_q;
    last_input_d = last_input_q;
    dir_level_d  = dir_level_q;
    duty_d       = brake_duty_q;
    mode_d       = bmrc_pkg::ModeEmergency;
    priority if (emergency) begin
      // ramp only while the vehicle still moves; stick activity not tracked
      dir_level_d = tighten_dir_q;
      if (moving) begin
        brake_duty_d = ramp_duty;
      end
      duty_d = moving ? ramp_duty : brake_duty_q;
      mode_d = bmrc_pkg::ModeEmergency;
    end else begin
      priority if (brake_req) begin
        brake_duty_d = ramp_duty;
        dir_level_d  = tighten_dir_q;
        duty_d       = ramp_duty;
        mode_d       = bmrc_pkg::ModeBrake;
      end else if (timed_out) begin
        brake_duty_d = ramp_duty;
        dir_level_d  = tighten_dir_q;
        duty_d       = ramp_duty;
        mode_d       = bmrc_pkg::ModeTimeout;
      end else if (pot_low) begin
        dir_level_d = 1'b1;
        duty_d      = bmrc_pkg::BaseDuty;
        mode_d      = bmrc_pkg::ModeRecenterL;
      end else if (pot_high) begin
        dir_level_d = 1'b0;
        duty_d      = bmrc_pkg::BaseDuty;
        mode_d      = bmrc_pkg::ModeRecenterR;
      end else begin
        // centered: release and restart the ramp clock
        duty_d       = '0;
        brake_duty_d = bmrc_pkg::BaseDuty;
        ramp_start_d = now_time;
        mode_d       = bmrc_pkg::ModeReleased;
      end
      if (stick_active) begin
        last_input_d = now_time;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brake_duty_q <= bmrc_pkg::BaseDuty;
      ramp_start_q <= '0;
      last_input_q <= '0;
      dir_level_q  <= 1'b0;
    end else if (advance) begin
      brake_duty_q <= brake_duty_d;
      ramp_start_q <= ramp_start_d;
      last_input_q <= last_input_d;
      dir_level_q  <= dir_level_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_dir_q  <= dir_level_d;
      out_duty_q <= duty_d;
      out_mode_q <= mode_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(bmrc_pkg::OutDataW - bmrc_pkg::OutFieldsW){1'b0}},
                            out_mode_q, out_duty_q, out_dir_q};

endmodule

// ----- sv/bmrc_checker.sv -----
// Port-level checker for the brake motor ramp controller, with its bind.
`include "brake_motor_ramp_controller_defines.svh"

module bmrc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [bmrc_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  logic                    out_dir;
  logic [7:0]              out_duty;
  logic [2:0]              out_mode;
  logic                    recenter;

  assign out_dir  = m_axis_tdata_o[0];
  assign out_duty = m_axis_tdata_o[8:1];
  assign out_mode = m_axis_tdata_o[11:9];
  assign recenter = (out_mode == bmrc_pkg::ModeRecenterL)
                 || (out_mode == bmrc_pkg::ModeRecenterR);

  // stalled result holds
  `BMRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                    m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // a sink that takes results never blocks the source
  `BMRC_ASSERT_NOW(a_ready_flow, m_axis_tready_i, s_axis_tready_o)

  // release drives no duty
  `BMRC_ASSERT_NOW(a_release_duty, m_axis_tvalid_o && (out_mode == bmrc_pkg::ModeReleased),
                   out_duty == 8'd0)

  // recenter uses base duty and the matching direction
  `BMRC_ASSERT_NOW(a_recenter, m_axis_tvalid_o && recenter,
                   (out_duty == bmrc_pkg::BaseDuty)
                   && (out_dir == (out_mode == bmrc_pkg::ModeRecenterL)))

endmodule

bind brake_motor_ramp_controller bmrc_checker u_bmrc_checker (.*);

// ----- bench/tb_brake_motor_ramp_controller.sv -----
// Testbench for the brake motor ramp controller: directed and random ticks checked against a predictor.
`timescale 1ns / 100ps

module tb_brake_motor_ramp_controller;

  // One control tick as it sits in s_axis_tdata, stick_y in the low bits.
  typedef struct packed {
    logic [bmrc_pkg::PotW-1:0]   pot;
    logic                        emerg;
    logic [bmrc_pkg::SpeedW-1:0] speed;
    logic [bmrc_pkg::TimeW-1:0]  now;
    logic [bmrc_pkg::StickW-1:0] stick_x;
    logic [bmrc_pkg::StickW-1:0] stick_y;
  } tick_t;

  // One motor command as it sits in m_axis_tdata, direction in bit 0.
  typedef struct packed {
    bmrc_pkg::mode_e            mode;
    logic [bmrc_pkg::DutyW-1:0] duty;
    logic                       dir;
  } motor_cmd_t;

  localparam int unsigned RampStep      = 40;    // duty counts per ramp period
  localparam int unsigned RampPeriod    = 1000;  // ticks
  localparam int unsigned WatchdogLimit = 500;   // cycles with no item moving on either side
  localparam int unsigned SettleCycles  = 4;     // two-stage pipeline plus margin
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned RandomTicks   = 2000;
  localparam int unsigned NumPhases     = 9;

  // Scoreboard: shadows the registers and the controller state, predicts one
  // motor command per accepted tick and checks results in order.
  class brake_cmd_checker;
    bit                       tighten_dir;
    bit [bmrc_pkg::PotW-1:0]  pot_center;
    bit [bmrc_pkg::TimeW-1:0] no_input_delay;
    bit [bmrc_pkg::DutyW-1:0] max_duty;

    bit [bmrc_pkg::DutyW-1:0] brake_duty;
    bit [bmrc_pkg::TimeW-1:0] ramp_start;
    bit [bmrc_pkg::TimeW-1:0] last_input;
    bit                       dir_level;

    motor_cmd_t  expected_cmds[$];
    int unsigned mismatches;
    int unsigned cmds_seen;

    function new();
      tighten_dir    = bmrc_pkg::RstTightenDir;
      pot_center     = bmrc_pkg::RstPotCenter;
      no_input_delay = bmrc_pkg::RstNoInputDly;
      max_duty       = bmrc_pkg::RstMaxDuty;
      brake_duty     = bmrc_pkg::BaseDuty;
      ramp_start     = '0;
      last_input     = '0;
      dir_level      = 1'b0;
      mismatches     = 0;
      cmds_seen      = 0;
    endfunction

    function void write_reg(input logic [bmrc_pkg::CfgIdxW-1:0] idx,
                            input logic [bmrc_pkg::CfgDataW-1:0] value);
      case (idx)
        bmrc_pkg::CfgTightenDir: tighten_dir    = value[0];
        bmrc_pkg::CfgPotCenter:  pot_center     = value[bmrc_pkg::PotW-1:0];
        bmrc_pkg::CfgNoInputDly: no_input_delay = value[bmrc_pkg::TimeW-1:0];
        bmrc_pkg::CfgMaxDuty:    max_duty       = value[bmrc_pkg::DutyW-1:0];
        default: ;
      endcase
    endfunction

    // Ramp since last release, saturated at 255, never lowers the duty, then clamped.
    function void apply_ramp(input bit [bmrc_pkg::TimeW-1:0] now);
      bit [bmrc_pkg::TimeW-1:0] elapsed;
      bit [63:0]                term;
      elapsed = now - ramp_start;
      term = (64'(elapsed) * 64'(RampStep)) / 64'(RampPeriod);
      if (term > 64'(bmrc_pkg::DutySat)) term = 64'(bmrc_pkg::DutySat);
      if (term[bmrc_pkg::DutyW-1:0] > brake_duty) brake_duty = term[bmrc_pkg::DutyW-1:0];
      if (brake_duty > max_duty) brake_duty = max_duty;
    endfunction

    function void note_tick(input tick_t t);
      motor_cmd_t             cmd;
      bit [bmrc_pkg::TimeW:0] deadline;
      int                     pot;
      int                     center;
      bit                     x_idle;
      bit                     y_idle;
      deadline = {1'b0, last_input} + {1'b0, no_input_delay};
      pot      = int'(t.pot);
      center   = int'(pot_center);
      x_idle   = t.stick_x >= bmrc_pkg::IdleLow && t.stick_x <= bmrc_pkg::IdleHigh;
      y_idle   = t.stick_y >= bmrc_pkg::IdleLow && t.stick_y <= bmrc_pkg::IdleHigh;
      if (t.emerg) begin
        // ramp only while moving; standing still, the duty is held
        dir_level = tighten_dir;
        if (t.speed >= bmrc_pkg::SpeedMoveFx) apply_ramp(t.now);
        cmd.duty = brake_duty;
        cmd.mode = bmrc_pkg::ModeEmergency;
      end else begin
        if (t.stick_y > bmrc_pkg::StickDown || t.speed > bmrc_pkg::SpeedHighFx) begin
          apply_ramp(t.now);
          dir_level = tighten_dir;
          cmd.duty  = brake_duty;
          cmd.mode  = bmrc_pkg::ModeBrake;
        end else if (deadline < {1'b0, t.now}) begin
          apply_ramp(t.now);
          dir_level = tighten_dir;
          cmd.duty  = brake_duty;
          cmd.mode  = bmrc_pkg::ModeTimeout;
        end else if (pot < center - int'(bmrc_pkg::PotBand)) begin
          dir_level = 1'b1;
          cmd.duty  = bmrc_pkg::BaseDuty;
          cmd.mode  = bmrc_pkg::ModeRecenterL;
        end else if (pot > center + int'(bmrc_pkg::PotBand)) begin
          dir_level = 1'b0;
          cmd.duty  = bmrc_pkg::BaseDuty;
          cmd.mode  = bmrc_pkg::ModeRecenterR;
        end else begin
          // centered: release, restart the ramp clock
          cmd.duty   = '0;
          brake_duty = bmrc_pkg::BaseDuty;
          ramp_start = t.now;
          cmd.mode   = bmrc_pkg::ModeReleased;
        end
        if (!x_idle || !y_idle) last_input = t.now;
      end
      cmd.dir = dir_level;
      expected_cmds.push_back(cmd);
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    task check_cmd(input logic [bmrc_pkg::OutDataW-1:0] data);
      motor_cmd_t                 want;
      logic                       got_dir;
      logic [bmrc_pkg::DutyW-1:0] got_duty;
      logic [bmrc_pkg::ModeW-1:0] got_mode;
      cmds_seen++;
      got_dir  = data[0];
      got_duty = data[bmrc_pkg::DutyW:1];
      got_mode = data[bmrc_pkg::DutyW+bmrc_pkg::ModeW:bmrc_pkg::DutyW+1];
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", cmds_seen));
        return;
      end
      want = expected_cmds.pop_front();
      if (got_mode !== want.mode)
        report_mismatch($sformatf("result %0d: mode %0d, expected %0d (%s)",
                                  cmds_seen, got_mode, want.mode, want.mode.name()));
      if (got_duty !== want.duty)
        report_mismatch($sformatf("result %0d: duty %0d, expected %0d",
                                  cmds_seen, got_duty, want.duty));
      if (got_dir !== want.dir)
        report_mismatch($sformatf("result %0d: direction %0b, expected %0b",
                                  cmds_seen, got_dir, want.dir));
    endtask

    function int unsigned pending();
      return expected_cmds.size();
    endfunction
  endclass

  logic                          clk      = 1'b0;
  logic                          rst_n    = 1'b0;
  logic                          cfg_we   = 1'b0;
  logic [bmrc_pkg::CfgIdxW-1:0]  cfg_idx  = '0;
  logic [bmrc_pkg::CfgDataW-1:0] cfg_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [bmrc_pkg::InDataW-1:0]  s_tdata  = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [bmrc_pkg::OutDataW-1:0] m_tdata;

  brake_cmd_checker cmd_check = new();

  int unsigned              send_gap_max   = 8;
  int unsigned              sink_stall_max = 8;
  bit [bmrc_pkg::TimeW-1:0] tick_time;       // running time stamp for random ticks
  int unsigned              stalled_cycles = 0;

  brake_motor_ramp_controller dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic tick_t mk_tick(input logic [bmrc_pkg::StickW-1:0] sy,
                                    input logic [bmrc_pkg::StickW-1:0] sx,
                                    input logic [bmrc_pkg::TimeW-1:0] now,
                                    input logic [bmrc_pkg::SpeedW-1:0] spd,
                                    input logic em, input logic [bmrc_pkg::PotW-1:0] pot);
    tick_t t;
    t.stick_y = sy;
    t.stick_x = sx;
    t.now     = now;
    t.speed   = spd;
    t.emerg   = em;
    t.pot     = pot;
    return t;
  endfunction

  // Offer one tick after a random gap; valid stays up across back-to-back items.
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= bmrc_pkg::InDataW'(t);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    cmd_check.note_tick(t);
  endtask

  // Mostly plausible ticks: forward-moving time, idle sticks, pot near center,
  // plus boundary values and full-range noise on every field.
  task automatic send_random_tick();
    logic [bmrc_pkg::StickW-1:0] sy;
    logic [bmrc_pkg::StickW-1:0] sx;
    logic [bmrc_pkg::SpeedW-1:0] spd;
    logic [bmrc_pkg::PotW-1:0]   pot;
    logic                        em;
    int unsigned                 pick;
    int                          c;
    int                          lo;
    int                          hi;
    pick = $urandom_range(0, 99);
    if (pick < 2) tick_time = $urandom();
    else if (pick < 10) tick_time += $urandom_range(2000, 10000);
    else if (pick < 30) tick_time += $urandom_range(100, 2000);
    else if (pick >= 38) tick_time += $urandom_range(1, 100);

    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      sy = bmrc_pkg::StickW'($urandom_range(bmrc_pkg::IdleLow, bmrc_pkg::IdleHigh));
    end else if (pick < 60) begin
      sy = bmrc_pkg::StickW'($urandom_range(bmrc_pkg::StickDown + 1, 255));
    end else if (pick < 70) begin
      sy = bmrc_pkg::StickW'($urandom_range(bmrc_pkg::IdleLow - 1, bmrc_pkg::StickDown + 1));
    end else begin
      sy = bmrc_pkg::StickW'($urandom_range(0, 255));
    end

    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      sx = bmrc_pkg::StickW'($urandom_range(bmrc_pkg::IdleLow, bmrc_pkg::IdleHigh));
    end else if (pick < 65) begin
      sx = bmrc_pkg::StickW'($urandom_range(bmrc_pkg::IdleLow - 2, bmrc_pkg::IdleHigh + 2));
    end else begin
      sx = bmrc_pkg::StickW'($urandom_range(0, 255));
    end

    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      spd = bmrc_pkg::SpeedW'($urandom_range(0, bmrc_pkg::SpeedHighFx));
    end else if (pick < 62) begin
      spd = bmrc_pkg::SpeedW'($urandom_range(bmrc_pkg::SpeedMoveFx - 2,
                                             bmrc_pkg::SpeedMoveFx + 2));
    end else if (pick < 70) begin
      spd = bmrc_pkg::SpeedW'($urandom_range(bmrc_pkg::SpeedHighFx - 2,
                                             bmrc_pkg::SpeedHighFx + 2));
    end else begin
      spd = bmrc_pkg::SpeedW'($urandom_range(0, 4095));
    end

    em = ($urandom_range(0, 9) == 0);

    c  = int'(cmd_check.pot_center);
    lo = (c < 8) ? 0 : c - 8;
    hi = (c > 1015) ? 1023 : c + 8;
    if ($urandom_range(0, 99) < 55) pot = bmrc_pkg::PotW'($urandom_range(lo, hi));
    else pot = bmrc_pkg::PotW'($urandom_range(0, 1023));

    send_tick(mk_tick(sy, sx, tick_time, spd, em, pot));
  endtask

  // Stop offering items, let every expected command arrive, then let the pipe settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (cmd_check.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bmrc_pkg::CfgIdxW-1:0] idx,
                           input logic [bmrc_pkg::CfgDataW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cmd_check.write_reg(idx, value);
  endtask

  task automatic set_config(input logic tighten, input logic [bmrc_pkg::PotW-1:0] center,
                            input logic [bmrc_pkg::TimeW-1:0] delay,
                            input logic [bmrc_pkg::DutyW-1:0] max_duty);
    drain_results();
    write_reg(bmrc_pkg::CfgTightenDir, bmrc_pkg::CfgDataW'(tighten));
    write_reg(bmrc_pkg::CfgPotCenter, bmrc_pkg::CfgDataW'(center));
    write_reg(bmrc_pkg::CfgNoInputDly, bmrc_pkg::CfgDataW'(delay));
    write_reg(bmrc_pkg::CfgMaxDuty, bmrc_pkg::CfgDataW'(max_duty));
    cfg_we <= 1'b0;
  endtask

  // Result side: random stall before each item, ready held high across bursts.
  initial begin : result_sink
    int unsigned stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = $urandom_range(0, sink_stall_max);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      cmd_check.check_cmd(m_tdata);
    end
  end

  // Watchdog: no item moving on either side for too long means a hang.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
      if (stalled_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks, reset configuration (center 512, delay 100000, clamp 50).
    // Args: stick_y, stick_x, now, speed, emergency, pot.
    send_tick(mk_tick(128, 128, 0, 0, 0, 512));             // centered: release
    send_tick(mk_tick(128, 128, 10, 0, 0, 506));            // just outside band, low side
    send_tick(mk_tick(128, 128, 20, 0, 0, 507));            // band edge: still released
    send_tick(mk_tick(128, 128, 30, 0, 0, 518));            // just outside band, high side
    send_tick(mk_tick(128, 128, 40, 0, 0, 517));            // band edge, high side
    send_tick(mk_tick(135, 128, 1000, 0, 0, 512));          // stick at threshold: no brake
    send_tick(mk_tick(136, 128, 3000, 0, 0, 512));          // stick down: ramp hits clamp
    send_tick(mk_tick(128, 128, 3000, 160, 0, 512));        // speed exactly 10: no brake
    send_tick(mk_tick(128, 128, 3025, 161, 0, 512));        // speed above 10: brake at base duty
    send_tick(mk_tick(128, 128, 10000, 15, 1, 512));        // emergency standing: duty held
    send_tick(mk_tick(128, 128, 10000, 16, 1, 512));        // emergency moving: ramp runs
    send_tick(mk_tick(255, 0, 'hFFFF_FFFF, 4095, 1, 1023)); // emergency, field extremes
    send_tick(mk_tick(124, 132, 100000, 0, 0, 512));        // idle window edges
    send_tick(mk_tick(128, 128, 103000, 0, 0, 512));        // deadline equal: no timeout
    send_tick(mk_tick(123, 133, 103001, 0, 0, 512));        // one past: timeout brake
    send_tick(mk_tick(0, 0, 206003, 0, 0, 0));              // timeout, ramp saturates
    send_tick(mk_tick(0, 255, 206004, 0, 0, 0));            // recenter left from pot 0
    send_tick(mk_tick(0, 255, 206005, 0, 0, 1023));         // recenter right from pot max
    send_tick(mk_tick(0, 0, 'hFFFF_FF00, 0, 0, 512));       // late stamp: timeout
    send_tick(mk_tick(128, 128, 'hFFFF_FF10, 0, 0, 512));   // deadline past 2^32: no wrap
    send_tick(mk_tick(128, 128, 'h0000_0100, 16, 1, 512));  // elapsed wraps through zero
    send_tick(mk_tick(128, 128, 'h0000_1488, 16, 1, 0));    // emergency overrides recenter
    send_tick(mk_tick(200, 100, 'h0000_2000, 0, 0, 300));   // stick brake
    send_tick(mk_tick(128, 128, 'h0000_3000, 4095, 0, 512)); // max speed brake
    tick_time = 'h0000_3000;

    // Random phases, each under its own register setting; the clamp drops below
    // a ramped duty in later phases.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: set_config(1'b1, 10'd512, 32'd100000, 8'd50);
        1: set_config(1'b0, 10'd0, 32'd0, 8'd255);
        2: set_config(1'b1, 10'd1023, 32'hFFFF_FFFF, 8'd0);
        3: set_config(1'b0, bmrc_pkg::PotW'($urandom()), 32'd300,
                      bmrc_pkg::DutyW'($urandom()));
        4: set_config(1'b1, 10'd5, 32'd2000, 8'd255);
        5: set_config(1'b1, 10'd1018, 32'd50, 8'd100);
        6: set_config(1'($urandom()), bmrc_pkg::PotW'($urandom()), $urandom_range(0, 5000),
                      bmrc_pkg::DutyW'($urandom()));
        7: set_config(1'b0, 10'd512, 32'd100000, 8'd0);
        default: set_config(1'($urandom()), bmrc_pkg::PotW'($urandom()), $urandom(),
                            bmrc_pkg::DutyW'($urandom()));
      endcase
      // some phases run without gaps on one or both sides
      send_gap_max   = (ph == 1 || ph == 5) ? 0 : 8;
      sink_stall_max = (ph == 1 || ph == 6) ? 0 : 8;
      repeat (RandomTicks / NumPhases) send_random_tick();
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (cmd_check.mismatches == 0 && cmd_check.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/bmrc_pkg.sv
sv/brake_motor_ramp_controller.sv
sv/bmrc_checker.sv
bench/tb_brake_motor_ramp_controller.sv
